// File: rtl/smpq_pkg.sv
`timescale 1ns / 1ps
package smpq_pkg;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PRE,
    S_SHIFT
  } state_t;

  // one input word
  typedef struct packed {
    logic        operation;
    logic [7:0]  priority_req;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
    logic [7:0]  min_capacity;
    logic [15:0] resource_code;
  } cmd_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic [7:0]  out_priority;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [4:0]  out_start_hour;
    logic [5:0]  out_start_minute;
    logic [4:0]  out_end_hour;
    logic [5:0]  out_end_minute;
    logic [7:0]  out_min_capacity;
    logic [15:0] out_resource_code;
    logic [4:0]  occupancy;
  } result_t;

  // stored booking record
  typedef struct packed {
    logic [7:0]  prio;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
    logic [7:0]  min_capacity;
    logic [15:0] resource_code;
  } rec_t;

  // response from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    status_t    status;
    rec_t       rec;
    logic [4:0] occupancy;
  } resp_t;

  localparam int OCC_W = 5;

endpackage

// File: rtl/smpq_mem.sv
`timescale 1ns / 1ps
module smpq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  smpq_pkg::rec_t     wdata,
  input  logic [AW-1:0]      raddr,
  output smpq_pkg::rec_t     rdata
);

  smpq_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/smpq_ctrl.sv
`timescale 1ns / 1ps
module smpq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  smpq_pkg::rec_t     in_rec,
  output logic               busy,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output smpq_pkg::rec_t     wdata,
  output logic [AW-1:0]      raddr,
  input  smpq_pkg::rec_t     rdata,
  output smpq_pkg::resp_t    resp
);

  smpq_pkg::state_t state, state_next;
  logic [CW-1:0]    count;
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    best;
  smpq_pkg::rec_t   best_rec;

  logic             accept;
  logic             is_deq;
  logic             full;
  logic             empty;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    count_p1;
  logic [AW-1:0]    last;
  logic [AW-1:0]    ptr_p1;
  logic [AW-1:0]    ptr_p2;
  logic             take;
  logic [AW-1:0]    best_sel;
  logic [CW-1:0]    occ_src;
  logic [CW+smpq_pkg::OCC_W-1:0] occ_wide;

  assign accept   = start && (state == smpq_pkg::S_IDLE);
  assign is_deq   = (op == smpq_pkg::OP_DEQUEUE);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - CW'(1);
  assign count_p1 = count + CW'(1);
  assign last     = count_m1[AW-1:0];
  assign ptr_p1   = ptr + AW'(1);
  assign ptr_p2   = ptr + AW'(2);

  // shared compare: first entry or strictly smaller priority wins
  assign take     = (ptr == '0) || (rdata.prio < best_rec.prio);
  assign best_sel = take ? ptr : best;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      smpq_pkg::S_IDLE: begin
        if (accept && is_deq && !empty) begin
          state_next = smpq_pkg::S_SCAN;
        end
      end
      smpq_pkg::S_SCAN: begin
        if (ptr == last) begin
          state_next = smpq_pkg::S_PRE;
        end
      end
      smpq_pkg::S_PRE: begin
        state_next = smpq_pkg::S_SHIFT;
      end
      smpq_pkg::S_SHIFT: begin
        if (ptr == last) begin
          state_next = smpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = smpq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy         = (state != smpq_pkg::S_IDLE);
    we           = 1'b0;
    waddr        = ptr;
    wdata        = rdata;
    raddr        = '0;
    resp.valid   = 1'b0;
    resp.status  = smpq_pkg::STAT_OK;
    resp.rec     = '0;
    occ_src      = count;
    case (state)
      smpq_pkg::S_IDLE: begin
        if (accept) begin
          resp.valid = !is_deq || empty;
          if (is_deq) begin
            resp.status = smpq_pkg::STAT_EMPTY;
          end else if (full) begin
            resp.status = smpq_pkg::STAT_FULL;
          end else begin
            we      = 1'b1;
            waddr   = count[AW-1:0];
            wdata   = in_rec;
            occ_src = count_p1;
          end
        end
      end
      smpq_pkg::S_SCAN: begin
        raddr = ptr_p1;
      end
      smpq_pkg::S_PRE: begin
        raddr = ptr_p1;
      end
      smpq_pkg::S_SHIFT: begin
        raddr = ptr_p2;
        if (ptr != last) begin
          we = 1'b1;
        end else begin
          resp.valid = 1'b1;
          resp.rec   = best_rec;
          occ_src    = count_m1;
        end
      end
      default: begin
        raddr = '0;
      end
    endcase
    occ_wide       = {{smpq_pkg::OCC_W{1'b0}}, occ_src};
    resp.occupancy = occ_wide[smpq_pkg::OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && !is_deq && !full) begin
        count <= count_p1;
      end
      if (state == smpq_pkg::S_SHIFT && ptr == last) begin
        count <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      smpq_pkg::S_IDLE: begin
        ptr <= '0;
      end
      smpq_pkg::S_SCAN: begin
        if (take) begin
          best     <= ptr;
          best_rec <= rdata;
        end
        ptr <= (ptr == last) ? best_sel : ptr_p1;
      end
      smpq_pkg::S_SHIFT: begin
        ptr <= ptr_p1;
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

endmodule

// File: rtl/stable_min_priority_queue.sv
`timescale 1ns / 1ps
// channel   ports                      handshake
// -------   -------------------------  ------------------------------------------
// command   cmd, start, busy           word taken at clk edge with start & !busy
// result    result, done               word valid for one cycle while done is high
//
// an enqueue or a refused item answers in the cycle after it is taken and busy
// stays low, so a new word may follow at once
// a dequeue of n held bookings keeps busy high through a scan of all n, a setup
// state and a shift from pos (the place of the removed booking) to the last one;
// the single memory read port sets this
// rst is synchronous and empties the queue; stored records are not cleared
// the receiver cannot stall: done pulses exactly once per accepted word
module stable_min_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  smpq_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done,
  output smpq_pkg::result_t  result
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // booking fields packed as one stored record
  smpq_pkg::rec_t  in_rec;
  smpq_pkg::rec_t  rdata;
  smpq_pkg::rec_t  wdata;
  smpq_pkg::resp_t resp;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;

  always_comb begin
    in_rec.prio          = cmd.priority_req;
    in_rec.day           = cmd.day;
    in_rec.month         = cmd.month;
    in_rec.year          = cmd.year;
    in_rec.start_hour    = cmd.start_hour;
    in_rec.start_minute  = cmd.start_minute;
    in_rec.end_hour      = cmd.end_hour;
    in_rec.end_minute    = cmd.end_minute;
    in_rec.min_capacity  = cmd.min_capacity;
    in_rec.resource_code = cmd.resource_code;
  end

  // record store: one write port, one registered read port
  smpq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer: min scan with one comparator, then the gap-closing shift
  smpq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (cmd.operation),
    .in_rec (in_rec),
    .busy   (busy),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata),
    .resp   (resp)
  );

  // result register, strobe reset only
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= resp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.valid) begin
      result.status            <= resp.status;
      result.out_priority      <= resp.rec.prio;
      result.out_day           <= resp.rec.day;
      result.out_month         <= resp.rec.month;
      result.out_year          <= resp.rec.year;
      result.out_start_hour    <= resp.rec.start_hour;
      result.out_start_minute  <= resp.rec.start_minute;
      result.out_end_hour      <= resp.rec.end_hour;
      result.out_end_minute    <= resp.rec.end_minute;
      result.out_min_capacity  <= resp.rec.min_capacity;
      result.out_resource_code <= resp.rec.resource_code;
      result.occupancy         <= resp.occupancy;
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 1425;
  // tail long enough for the worst dequeue to finish, plus its answer
  localparam int TAIL_CYCLES = 2 * DEPTH + 4;

  // one row of the directed part: the word and, where obvious, its answer
  typedef struct {
    smpq_pkg::cmd_t    word;
    bit                known;
    smpq_pkg::result_t want;
  } directed_row_t;

  // typed answer travelling alongside each word, in issue order
  typedef struct {
    bit                known;
    smpq_pkg::result_t value;
  } typed_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  smpq_pkg::cmd_t    cmd = '0;
  logic              busy;
  logic              done;
  smpq_pkg::result_t result;

  // bookings held by the predictor, oldest first
  smpq_pkg::rec_t    booking_queue[$];
  // answers still owed by the block, oldest first
  smpq_pkg::result_t awaited_results[$];
  typed_answer_t     typed_answers[$];
  directed_row_t     plan[$];
  int                fail_count = 0;

  stable_min_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor: apply one word to the booking queue and return its answer
  function automatic smpq_pkg::result_t predict_booking_result(smpq_pkg::cmd_t w);
    smpq_pkg::result_t r;
    smpq_pkg::rec_t    b;
    int                best;
    r = '0;
    r.status = smpq_pkg::STAT_OK;
    if (w.operation == smpq_pkg::OP_ENQUEUE) begin
      // a full queue refuses the booking and keeps everything as it was
      if (booking_queue.size() >= DEPTH) begin
        r.status = smpq_pkg::STAT_FULL;
      end else begin
        b.prio          = w.priority_req;
        b.day           = w.day;
        b.month         = w.month;
        b.year          = w.year;
        b.start_hour    = w.start_hour;
        b.start_minute  = w.start_minute;
        b.end_hour      = w.end_hour;
        b.end_minute    = w.end_minute;
        b.min_capacity  = w.min_capacity;
        b.resource_code = w.resource_code;
        booking_queue.push_back(b);
      end
    end else if (booking_queue.size() == 0) begin
      r.status = smpq_pkg::STAT_EMPTY;
    end else begin
      // strict less-than keeps the oldest booking among equal priorities
      best = 0;
      for (int i = 1; i < booking_queue.size(); i++) begin
        if (booking_queue[i].prio < booking_queue[best].prio) best = i;
      end
      b = booking_queue[best];
      r.out_priority      = b.prio;
      r.out_day           = b.day;
      r.out_month         = b.month;
      r.out_year          = b.year;
      r.out_start_hour    = b.start_hour;
      r.out_start_minute  = b.start_minute;
      r.out_end_hour      = b.end_hour;
      r.out_end_minute    = b.end_minute;
      r.out_min_capacity  = b.min_capacity;
      r.out_resource_code = b.resource_code;
      // the bookings behind close the gap in order
      booking_queue.delete(best);
    end
    r.occupancy = 5'(booking_queue.size());
    return r;
  endfunction

  // answer with only a status and an occupancy, all booking fields zero
  function automatic smpq_pkg::result_t plain_answer(smpq_pkg::status_t s, int occ);
    smpq_pkg::result_t r;
    r = '0;
    r.status = s;
    r.occupancy = 5'(occ);
    return r;
  endfunction

  // booking with random bits in every field; half of them draw from a
  // narrow priority span so that ties are common
  function automatic smpq_pkg::cmd_t random_booking(smpq_pkg::op_t op);
    logic [95:0]    bits;
    smpq_pkg::cmd_t w;
    bits = {$urandom(), $urandom(), $urandom()};
    w = bits[$bits(smpq_pkg::cmd_t)-1:0];
    w.operation = op;
    if ($urandom_range(0, 1) == 1) w.priority_req = 8'($urandom_range(0, 3));
    return w;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap(bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_result(smpq_pkg::result_t got, smpq_pkg::result_t want);
    report_field("status",            16'(want.status),            16'(got.status));
    report_field("out_priority",      16'(want.out_priority),      16'(got.out_priority));
    report_field("out_day",           16'(want.out_day),           16'(got.out_day));
    report_field("out_month",         16'(want.out_month),         16'(got.out_month));
    report_field("out_year",          16'(want.out_year),          16'(got.out_year));
    report_field("out_start_hour",    16'(want.out_start_hour),    16'(got.out_start_hour));
    report_field("out_start_minute",  16'(want.out_start_minute),  16'(got.out_start_minute));
    report_field("out_end_hour",      16'(want.out_end_hour),      16'(got.out_end_hour));
    report_field("out_end_minute",    16'(want.out_end_minute),    16'(got.out_end_minute));
    report_field("out_min_capacity",  16'(want.out_min_capacity),  16'(got.out_min_capacity));
    report_field("out_resource_code", want.out_resource_code,      got.out_resource_code);
    report_field("occupancy",         16'(want.occupancy),         16'(got.occupancy));
  endtask

  // present one word, hold it until the block takes it, then idle for the gap, if any
  task automatic send_word(smpq_pkg::cmd_t w, bit known, smpq_pkg::result_t want, int gap);
    typed_answer_t tag;
    tag.known = known;
    tag.value = want;
    typed_answers.push_back(tag);
    cmd   <= w;
    start <= 1'b1;
    // values seen right after the edge are the ones the block sampled
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_directed_plan();
    directed_row_t row;
    // empty queue refuses a dequeue
    row.word = '0;
    row.word.operation = smpq_pkg::OP_DEQUEUE;
    row.known = 1'b1;
    row.want = plain_answer(smpq_pkg::STAT_EMPTY, 0);
    plan.push_back(row);
    // every field at its all-ones extreme, beyond the calendar ranges
    row.word = '1;
    row.word.operation = smpq_pkg::OP_ENQUEUE;
    row.want = plain_answer(smpq_pkg::STAT_OK, 1);
    plan.push_back(row);
    // every field at zero
    row.word = '0;
    row.word.operation = smpq_pkg::OP_ENQUEUE;
    row.want = plain_answer(smpq_pkg::STAT_OK, 2);
    plan.push_back(row);
    // same priority as the previous booking: arrival order must decide
    row.word = {3{26'h2AA_AAAA}};
    row.word.operation = smpq_pkg::OP_ENQUEUE;
    row.word.priority_req = 8'd0;
    row.want = plain_answer(smpq_pkg::STAT_OK, 3);
    plan.push_back(row);
    // drain: the two zero-priority bookings in arrival order, then the rest
    row.word = '1;
    row.word.operation = smpq_pkg::OP_DEQUEUE;
    row.known = 1'b0;
    repeat (3) plan.push_back(row);
    row.known = 1'b1;
    row.want = plain_answer(smpq_pkg::STAT_EMPTY, 0);
    plan.push_back(row);
    // fill to the brim with repeating priorities
    for (int i = 0; i < DEPTH; i++) begin
      row.word = random_booking(smpq_pkg::OP_ENQUEUE);
      row.word.priority_req = 8'((i * 5) % 6);
      row.want = plain_answer(smpq_pkg::STAT_OK, i + 1);
      plan.push_back(row);
    end
    // one more booking bounces off the full queue
    row.word = random_booking(smpq_pkg::OP_ENQUEUE);
    row.want = plain_answer(smpq_pkg::STAT_FULL, DEPTH);
    plan.push_back(row);
  endtask

  // monitor: check each answer, then predict the word taken at this edge
  always @(posedge clk) begin
    smpq_pkg::result_t want;
    typed_answer_t     tag;
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: answer with none awaited, actual %0h", $time, result);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_result(result, want);
        end
      end
      if (start && !busy) begin
        want = predict_booking_result(cmd);
        tag = typed_answers.pop_front();
        // a typed-in answer takes the place of the predicted one
        if (tag.known) want = tag.value;
        awaited_results.push_back(want);
      end
    end
  end

  // stimulus
  initial begin
    smpq_pkg::cmd_t w;
    int             sent;
    int             burst;
    int             enqueue_pct;
    bit             no_idle;
    load_directed_plan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (plan[k]) send_word(plan[k].word, plan[k].known, plan[k].want, pick_gap(1'b0));

    // random part in bursts; each burst leans toward filling, draining or
    // neither, so full and empty are reached again and again
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: begin
          enqueue_pct = 75;
        end
        1: begin
          enqueue_pct = 25;
        end
        default: begin
          enqueue_pct = 50;
        end
      endcase
      // some bursts run back to back with no gaps at all
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        w = random_booking(($urandom_range(1, 100) <= enqueue_pct) ?
                           smpq_pkg::OP_ENQUEUE : smpq_pkg::OP_DEQUEUE);
        send_word(w, 1'b0, '0, pick_gap(no_idle));
        sent++;
      end
    end
    start <= 1'b0;

    // let the owed answers arrive, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
